>>> rtl/hmne_pkg.sv
// shared types and constants of the height map normal encoder
`timescale 1ns / 1ps
`default_nettype none
package hmne_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MASK = 2'd2;

	localparam logic [10:0] RST_ROW_WIDTH  = 11'd320;
	localparam logic [10:0] RST_ROW_COUNT  = 11'd200;
	localparam logic [7:0]  RST_COLOR_MASK = 8'd255;

	// fit unit: largest n in 0..127 with n*n*a <= b
	localparam int FIT_N_W  = 7;
	localparam int FIT_SQ_W = 2 * FIT_N_W;
	localparam int FIT_A_W  = 22;
	localparam int FIT_B_W  = 34;
	localparam int FIT_P_W  = FIT_SQ_W + FIT_A_W;

	localparam logic [FIT_B_W-1:0] Z_BOUND = 34'd16646400;
	localparam logic [15:0]        GAIN    = 16'd65025;
	localparam logic [19:0]        Q_BIAS  = 20'd1024;

	// result slots within one request
	localparam logic [1:0] RES_UP_LEFT   = 2'd0;
	localparam logic [1:0] RES_UP_RIGHT  = 2'd1;
	localparam logic [1:0] RES_CUR_LEFT  = 2'd2;
	localparam logic [1:0] RES_CUR_RIGHT = 2'd3;

	typedef struct packed {
		logic [7:0] height;
		logic [7:0] color;
	} pix_t;

	typedef struct packed {
		logic [9:0]        out_col;
		logic [9:0]        out_row;
		logic signed [7:0] normal_x;
		logic signed [7:0] normal_y;
		logic [6:0]        normal_z;
		logic [7:0]        masked_color;
		logic              last;
	} nrm_t;

	typedef struct packed {
		logic       load;
		logic       rd_right;
		logic       cap_left;
		logic       cap_right;
		logic       wr_left;
		logic       wr_right;
		logic       calc;
		logic       square;
		logic       prep;
		logic       fit_start;
		logic [1:0] sel;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic has_out;
		logic row_end;
		logic last_row;
		logic fit_busy;
	} sts_t;

endpackage
`default_nettype wire

>>> rtl/height_map_normal_encoder_core.sv
// top level of the height map normal encoder
`timescale 1ns / 1ps
`default_nettype none
// Turns a raster stream of height-map pixels (8-bit height, 8-bit color) into
// a normal map, one pixel request at a time. A line buffer of MAX_WIDTH
// entries holds the previous row; when pixel (x+1,y+1) arrives the normal of
// (x,y) is formed from its 2x2 neighborhood and sent with row, column and the
// masked color. Row 0 and column 0 give no results; the last column and last
// row repeat the neighboring normal with their own color, so a request gives
// 0 to 4 results, the final one flagged by last. A request that gives no
// result holds the input through the accept and the line buffer states RD0,
// RD1 and RD2 on its single read and single write port. A request with
// results waits for the normalization before its first result: three 7-bit
// searches run side by side, each bit a square and then a product against
// the squared norm; the results then follow one per cycle when the output
// side does not stall. The input is stalled until the last result of the
// request is taken. row_width and row_count are saturated to 2..MAX_WIDTH
// and 2..MAX_HEIGHT; the line buffer needs no clearing pass, its entries are
// always written before a read of them is used.
module height_map_normal_encoder_core
	import hmne_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// pixel requests
	input  wire logic                  pixel_valid,
	output logic                       pixel_stall,
	input  wire pix_t                  pixel,
	// normal results
	output logic                       normal_valid,
	input  wire logic                  normal_stall,
	output nrm_t                       normal,
	// configuration writes
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: read, arithmetic and emit phases
	hmne_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.normal_valid(normal_valid),
		.normal_stall(normal_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	// counters, line buffer and normal math
	hmne_datapath #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixel    (pixel),
		.cmd      (cmd),
		.sts      (sts),
		.normal   (normal)
	);

endmodule
`default_nettype wire

>>> rtl/hmne_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module hmne_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/hmne_fit.sv
// bitwise search for the largest n with n*n*a <= b
`timescale 1ns / 1ps
`default_nettype none
module hmne_fit
	import hmne_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [FIT_A_W-1:0] a,
	input  wire logic [FIT_B_W-1:0] b,
	output logic                    busy,
	output logic [FIT_N_W-1:0]      n
);

	logic [FIT_N_W-1:0]  n_q;
	logic [2:0]          idx_q;
	logic                phase_q;
	logic                busy_q;
	logic [FIT_SQ_W-1:0] sq_q;
	logic [FIT_N_W-1:0]  trial;
	logic [FIT_P_W-1:0]  prod;

	assign trial = n_q | (FIT_N_W'(1) << idx_q);
	assign prod  = FIT_P_W'(sq_q) * FIT_P_W'(a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			idx_q   <= '0;
			phase_q <= 1'b0;
			busy_q  <= 1'b0;
		end else if (start) begin
			n_q     <= '0;
			idx_q   <= 3'(FIT_N_W - 1);
			phase_q <= 1'b0;
			busy_q  <= 1'b1;
		end else if (busy_q) begin
			phase_q <= !phase_q;
			if (phase_q) begin
				if (prod <= FIT_P_W'(b)) begin
					n_q <= trial;
				end
				if (idx_q == 3'd0) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q - 3'd1;
				end
			end
		end
	end

	// square of the trial value, registered ahead of the wide product
	always_ff @(posedge clk) begin
		if (busy_q && !phase_q) begin
			sq_q <= FIT_SQ_W'(trial) * FIT_SQ_W'(trial);
		end
	end

	assign busy = busy_q;
	assign n    = n_q;

endmodule
`default_nettype wire

>>> rtl/hmne_datapath.sv
// line buffer, raster counters and normal arithmetic
`timescale 1ns / 1ps
`default_nettype none
module hmne_datapath
	import hmne_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire pix_t                  pixel,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	output nrm_t                       normal
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [10:0] rw_q, rc_q;
	logic [7:0]  mask_q;
	logic [CW-1:0] wm1, csat, col_q, c_q, cm1;
	logic [RW-1:0] hm1, rsat, row_q, r_q;
	logic row_end_c, last_row_c;
	logic row_end_q, last_row_q, has_out_q, cge1_q;
	pix_t cur_q, pp_q, prev_q, al_q, ar_q, rd_data, wr_data;
	logic [CW-1:0] rd_addr, wr_addr;
	logic wr_en;
	logic signed [8:0]  h1, h2;
	logic signed [10:0] s_q, d_q;
	logic [9:0]  ms, md;
	logic [17:0] ms_e, md_e, ss_q, dd_q;
	logic [19:0] q_q;
	logic [FIT_B_W-1:0] bs_q, bd_q;
	logic [FIT_N_W-1:0] nx_m, ny_m, nz;
	logic bx, by, bz;
	logic [CW-1:0] out_c;
	logic [RW-1:0] out_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rw_q   <= RST_ROW_WIDTH;
			rc_q   <= RST_ROW_COUNT;
			mask_q <= RST_COLOR_MASK;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROW_WIDTH:  rw_q   <= cfg_data;
				CFG_ROW_COUNT:  rc_q   <= cfg_data;
				CFG_COLOR_MASK: mask_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// geometry saturated to 2..max
	always_comb begin
		if (rw_q < 11'd2) begin
			wm1 = CW'(1);
		end else if (32'(rw_q) > MAX_WIDTH) begin
			wm1 = CW'(MAX_WIDTH - 1);
		end else begin
			wm1 = CW'(rw_q - 11'd1);
		end
		if (rc_q < 11'd2) begin
			hm1 = RW'(1);
		end else if (32'(rc_q) > MAX_HEIGHT) begin
			hm1 = RW'(MAX_HEIGHT - 1);
		end else begin
			hm1 = RW'(rc_q - 11'd1);
		end
	end

	assign csat       = (col_q > wm1) ? wm1 : col_q;
	assign rsat       = (row_q > hm1) ? hm1 : row_q;
	assign row_end_c  = (csat == wm1);
	assign last_row_c = (rsat == hm1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			prev_q     <= '0;
			row_end_q  <= 1'b0;
			last_row_q <= 1'b0;
			has_out_q  <= 1'b0;
			cge1_q     <= 1'b0;
		end else if (cmd.load) begin
			prev_q     <= pixel;
			row_end_q  <= row_end_c;
			last_row_q <= last_row_c;
			has_out_q  <= (rsat != '0) && (csat != '0);
			cge1_q     <= (csat != '0);
			if (row_end_c && last_row_c) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end_c) begin
				col_q <= '0;
				row_q <= rsat + RW'(1);
			end else begin
				col_q <= csat + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c_q   <= csat;
			r_q   <= rsat;
			cur_q <= pixel;
			pp_q  <= prev_q;
		end
		if (cmd.cap_left) begin
			al_q <= rd_data;
		end
		if (cmd.cap_right) begin
			ar_q <= rd_data;
		end
	end

	// previous row store, read at c-1 then c, written behind the reads
	assign cm1     = c_q - CW'(1);
	assign rd_addr = cmd.rd_right ? c_q : cm1;
	assign wr_addr = cmd.wr_left ? cm1 : c_q;
	assign wr_data = cmd.wr_left ? pp_q : cur_q;
	assign wr_en   = (cmd.wr_left && cge1_q) || (cmd.wr_right && row_end_q);

	hmne_ram #(
		.WIDTH($bits(pix_t)),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign h1   = signed'({1'b0, cur_q.height}) - signed'({1'b0, al_q.height});
	assign h2   = signed'({1'b0, pp_q.height}) - signed'({1'b0, ar_q.height});
	assign ms   = s_q[10] ? 10'(-s_q) : 10'(s_q);
	assign md   = d_q[10] ? 10'(-d_q) : 10'(d_q);
	assign ms_e = 18'(ms);
	assign md_e = 18'(md);

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			s_q <= 11'(h1) + 11'(h2);
			d_q <= 11'(h2) - 11'(h1);
		end
		if (cmd.square) begin
			ss_q <= ms_e * ms_e;
			dd_q <= md_e * md_e;
		end
		if (cmd.prep) begin
			q_q  <= 20'(ss_q) + 20'(dd_q) + Q_BIAS;
			bs_q <= FIT_B_W'(ss_q) * FIT_B_W'(GAIN);
			bd_q <= FIT_B_W'(dd_q) * FIT_B_W'(GAIN);
		end
	end

	hmne_fit u_fit_z (
		.clk(clk), .arst_n(arst_n), .start(cmd.fit_start),
		.a(FIT_A_W'(q_q)), .b(Z_BOUND), .busy(bz), .n(nz)
	);

	hmne_fit u_fit_x (
		.clk(clk), .arst_n(arst_n), .start(cmd.fit_start),
		.a({q_q, 2'b00}), .b(bs_q), .busy(bx), .n(nx_m)
	);

	hmne_fit u_fit_y (
		.clk(clk), .arst_n(arst_n), .start(cmd.fit_start),
		.a({q_q, 2'b00}), .b(bd_q), .busy(by), .n(ny_m)
	);

	assign sts.has_out  = has_out_q;
	assign sts.row_end  = row_end_q;
	assign sts.last_row = last_row_q;
	assign sts.fit_busy = bx || by || bz;

	assign out_c = cmd.sel[0] ? c_q : cm1;
	assign out_r = cmd.sel[1] ? r_q : (r_q - RW'(1));

	always_comb begin
		normal.out_col  = 10'(out_c);
		normal.out_row  = 10'(out_r);
		normal.normal_x = s_q[10] ? (8'd0 - 8'(nx_m)) : 8'(nx_m);
		normal.normal_y = d_q[10] ? (8'd0 - 8'(ny_m)) : 8'(ny_m);
		normal.normal_z = nz;
		normal.last     = cmd.last;
		unique case (cmd.sel)
			RES_UP_LEFT:   normal.masked_color = al_q.color & mask_q;
			RES_UP_RIGHT:  normal.masked_color = ar_q.color & mask_q;
			RES_CUR_LEFT:  normal.masked_color = pp_q.color & mask_q;
			RES_CUR_RIGHT: normal.masked_color = cur_q.color & mask_q;
			default:       normal.masked_color = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/hmne_ctrl.sv
// sequencer for one pixel request at a time
`timescale 1ns / 1ps
`default_nettype none
module hmne_ctrl
	import hmne_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pixel_valid,
	output logic      pixel_stall,
	output logic      normal_valid,
	input  wire logic normal_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RD0   = 4'd1;
	localparam logic [3:0] ST_RD1   = 4'd2;
	localparam logic [3:0] ST_RD2   = 4'd3;
	localparam logic [3:0] ST_CALC  = 4'd4;
	localparam logic [3:0] ST_SQ    = 4'd5;
	localparam logic [3:0] ST_PREP  = 4'd6;
	localparam logic [3:0] ST_GO    = 4'd7;
	localparam logic [3:0] ST_WAIT  = 4'd8;
	localparam logic [3:0] ST_EMIT  = 4'd9;

	logic [3:0] state_q, state_d;
	logic [1:0] sel_q, sel_d, sel_nx;
	logic       has_next;

	always_comb begin
		unique case (sel_q)
			RES_UP_LEFT: begin
				has_next = sts.row_end || sts.last_row;
				sel_nx   = sts.row_end ? RES_UP_RIGHT : RES_CUR_LEFT;
			end
			RES_UP_RIGHT: begin
				has_next = sts.last_row;
				sel_nx   = RES_CUR_LEFT;
			end
			RES_CUR_LEFT: begin
				has_next = sts.last_row && sts.row_end;
				sel_nx   = RES_CUR_RIGHT;
			end
			default: begin
				has_next = 1'b0;
				sel_nx   = RES_CUR_RIGHT;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		unique case (state_q)
			ST_IDLE: if (pixel_valid) state_d = ST_RD0;
			ST_RD0:  state_d = ST_RD1;
			ST_RD1:  state_d = ST_RD2;
			ST_RD2:  state_d = sts.has_out ? ST_CALC : ST_IDLE;
			ST_CALC: state_d = ST_SQ;
			ST_SQ:   state_d = ST_PREP;
			ST_PREP: state_d = ST_GO;
			ST_GO:   state_d = ST_WAIT;
			ST_WAIT: begin
				if (!sts.fit_busy) begin
					state_d = ST_EMIT;
					sel_d   = RES_UP_LEFT;
				end
			end
			ST_EMIT: begin
				if (!normal_stall) begin
					if (has_next) begin
						sel_d = sel_nx;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= RES_UP_LEFT;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	assign pixel_stall  = (state_q != ST_IDLE);
	assign normal_valid = (state_q == ST_EMIT);

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && pixel_valid;
		cmd.rd_right  = (state_q == ST_RD1);
		cmd.cap_left  = (state_q == ST_RD1);
		cmd.wr_left   = (state_q == ST_RD1);
		cmd.cap_right = (state_q == ST_RD2);
		cmd.wr_right  = (state_q == ST_RD2);
		cmd.calc      = (state_q == ST_CALC);
		cmd.square    = (state_q == ST_SQ);
		cmd.prep      = (state_q == ST_PREP);
		cmd.fit_start = (state_q == ST_GO);
		cmd.sel       = sel_q;
		cmd.last      = !has_next;
	end

endmodule
`default_nettype wire

>>> rtl/hmne_checker.sv
// port level checks of the normal encoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module hmne_checker
	import hmne_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pixel_valid,
	input wire logic pixel_stall,
	input wire logic normal_valid,
	input wire logic normal_stall,
	input wire nrm_t normal
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		normal_valid && normal_stall |=> normal_valid && $stable(normal))
		else $error("result changed while stalled");

	// no new request while results are pending
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		normal_valid |-> pixel_stall)
		else $error("request taken while results pending");

	// an accepted request is worked on before the next
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_stall |=> pixel_stall)
		else $error("back to back requests taken");

	// results of one request come without gaps
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		normal_valid && !normal_stall && !normal.last |=> normal_valid)
		else $error("gap inside a result burst");

endmodule

bind height_map_normal_encoder_core hmne_checker u_hmne_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_valid (pixel_valid),
	.pixel_stall (pixel_stall),
	.normal_valid(normal_valid),
	.normal_stall(normal_stall),
	.normal      (normal)
);
`default_nettype wire
